// ----- rtl/oriented_rectangle_overlap_macros.svh -----
// Assertion macros for the oriented rectangle overlap block
`ifndef ORIENTED_RECTANGLE_OVERLAP_MACROS_SVH
`define ORIENTED_RECTANGLE_OVERLAP_MACROS_SVH

// same-cycle implication
`define OROV_ASSERT_NOW(lbl, clk, rst_n, cond, res) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (res)) \
		else $error("orov assertion failed");

// next-cycle implication
`define OROV_ASSERT_NEXT(lbl, clk, rst_n, cond, res) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
		else $error("orov assertion failed");

`endif

// ----- rtl/orov_pkg.sv -----
// ---------------------------------------------------------------------------
// orov_pkg
// Shared constants for the oriented rectangle overlap pipeline.
// ---------------------------------------------------------------------------
package orov_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CX_W         = 34;   // Q30 CORDIC x/y with headroom
	localparam int Z_W          = 32;   // residual phase
	localparam int TRIG_W       = 16;   // Q14 sine/cosine, range +-16384
	localparam int TRIG_SHIFT   = 14;
	localparam int TOL_W        = 16;
	localparam int TOL_SHIFT    = 28;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int GEOM_LAT     = 6;

	localparam logic signed [CX_W-1:0] CORDIC_INIT = CX_W'(652032875);

	localparam logic signed [Z_W-1:0] ATAN_PHASE [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
	};

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

endpackage

// ----- rtl/orov_cordic.sv -----
// ---------------------------------------------------------------------------
// orov_cordic
// Pipelined rotation-mode CORDIC, one step per stage, with Q14 rounding,
// clamp and quadrant fold.
// ---------------------------------------------------------------------------
module orov_cordic import orov_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ANGLE_BITS-1:0]    angle,
	output logic signed [TRIG_W-1:0] cos_val,
	output logic signed [TRIG_W-1:0] sin_val
);

	logic signed [CX_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CX_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  z_s [CORDIC_STEPS+1];
	quad_t                  q_s [CORDIC_STEPS+1];

	logic [29:0] phase_lo;
	assign phase_lo = {angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_INIT;
			y_s[0] <= '0;
			z_s[0] <= Z_W'({2'b00, phase_lo});
			q_s[0] <= quad_t'(angle[ANGLE_BITS-1:ANGLE_BITS-2]);
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				q_s[i+1] <= q_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_PHASE[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_PHASE[i];
				end
			end
		end
	end

	localparam int RW = CX_W - 16;
	localparam logic signed [RW-1:0]     ONE_R = RW'(16384);
	localparam logic signed [TRIG_W-1:0] ONE_T = TRIG_W'(16384);

	logic signed [CX_W-1:0]   xr_sum, yr_sum;
	logic signed [RW-1:0]     xr, yr;
	logic signed [TRIG_W-1:0] c, s;

	always_comb begin
		xr_sum = x_s[CORDIC_STEPS] + CX_W'(32768);
		yr_sum = y_s[CORDIC_STEPS] + CX_W'(32768);
		xr     = xr_sum[CX_W-1:16];
		yr     = yr_sum[CX_W-1:16];
		if (xr > ONE_R)       c = ONE_T;
		else if (xr < -ONE_R) c = -ONE_T;
		else                  c = xr[TRIG_W-1:0];
		if (yr > ONE_R)       s = ONE_T;
		else if (yr < -ONE_R) s = -ONE_T;
		else                  s = yr[TRIG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[CORDIC_STEPS])
				QUAD_0: begin cos_val <= c;  sin_val <= s;  end
				QUAD_1: begin cos_val <= -s; sin_val <= c;  end
				QUAD_2: begin cos_val <= -c; sin_val <= -s; end
				default: begin cos_val <= s; sin_val <= -c; end
			endcase
		end
	end

endmodule

// ----- rtl/orov_geom.sv -----
// ---------------------------------------------------------------------------
// orov_geom
// Corner build, projection on four axes, interval min/max and separation
// test. Six register stages.
// ---------------------------------------------------------------------------
module orov_geom import orov_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [TRIG_W-1:0]     cos_a,
	input  logic signed [TRIG_W-1:0]     sin_a,
	input  logic signed [TRIG_W-1:0]     cos_b,
	input  logic signed [TRIG_W-1:0]     sin_b,
	input  logic [4*COORD_BITS-3:0]      shape_a,
	input  logic [4*COORD_BITS-3:0]      shape_b,
	input  logic [TOL_W-1:0]             tol,
	output logic                         hit
);

	localparam int CW   = COORD_BITS;
	localparam int PW   = CW + 16;            // corner width
	localparam int MW   = PW + TRIG_W;        // single product
	localparam int QW   = MW + 1;             // projection
	localparam int TW_S = TOL_W + TOL_SHIFT;
	localparam int KW   = ((QW > TW_S) ? QW : TW_S) + 2;

	// stage 1: anchor scale and extent products
	logic signed [PW-1:0]     bx_s1 [2], by_s1 [2];
	logic signed [PW-1:0]     cw_s1 [2], sw_s1 [2], ch_s1 [2], sh_s1 [2];
	logic signed [TRIG_W-1:0] c_s1 [2], s_s1 [2];

	logic signed [TRIG_W-1:0] cin [2], sin_in [2];
	logic [4*CW-3:0]          shp [2];
	assign cin[0] = cos_a; assign sin_in[0] = sin_a; assign shp[0] = shape_a;
	assign cin[1] = cos_b; assign sin_in[1] = sin_b; assign shp[1] = shape_b;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 2; r++) begin
				logic signed [PW-1:0] xe, ye, we, he, ce, se;
				xe = PW'($signed(shp[r][4*CW-3:3*CW-2]));
				ye = PW'($signed(shp[r][3*CW-3:2*CW-2]));
				we = PW'($signed({1'b0, shp[r][2*CW-3:CW-1]}));
				he = PW'($signed({1'b0, shp[r][CW-2:0]}));
				ce = PW'(cin[r]);
				se = PW'(sin_in[r]);
				bx_s1[r] <= xe <<< TRIG_SHIFT;
				by_s1[r] <= ye <<< TRIG_SHIFT;
				cw_s1[r] <= ce * we;
				sw_s1[r] <= se * we;
				ch_s1[r] <= ce * he;
				sh_s1[r] <= se * he;
				c_s1[r]  <= cin[r];
				s_s1[r]  <= sin_in[r];
			end
		end
	end

	// stage 2: corners and axes
	logic signed [PW-1:0]     px_s2 [2][4], py_s2 [2][4];
	logic signed [TRIG_W-1:0] ax_s2 [4], ay_s2 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 2; r++) begin
				px_s2[r][0] <= bx_s1[r];
				py_s2[r][0] <= by_s1[r];
				px_s2[r][1] <= bx_s1[r] + cw_s1[r];
				py_s2[r][1] <= by_s1[r] + sw_s1[r];
				px_s2[r][2] <= bx_s1[r] + cw_s1[r] - sh_s1[r];
				py_s2[r][2] <= by_s1[r] + sw_s1[r] + ch_s1[r];
				px_s2[r][3] <= bx_s1[r] - sh_s1[r];
				py_s2[r][3] <= by_s1[r] + ch_s1[r];
				ax_s2[2*r]   <= s_s1[r];
				ay_s2[2*r]   <= -c_s1[r];
				ax_s2[2*r+1] <= c_s1[r];
				ay_s2[2*r+1] <= s_s1[r];
			end
		end
	end

	// stage 3: products; stage 4: projections
	logic signed [MW-1:0] mx_s3 [4][2][4], my_s3 [4][2][4];
	logic signed [QW-1:0] p_s4 [4][2][4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 4; a++) begin
				for (int r = 0; r < 2; r++) begin
					for (int k = 0; k < 4; k++) begin
						mx_s3[a][r][k] <= MW'(px_s2[r][k]) * MW'(ax_s2[a]);
						my_s3[a][r][k] <= MW'(py_s2[r][k]) * MW'(ay_s2[a]);
						p_s4[a][r][k]  <= QW'(mx_s3[a][r][k]) + QW'(my_s3[a][r][k]);
					end
				end
			end
		end
	end

	// stage 5: interval bounds
	logic signed [QW-1:0] lo_s5 [4][2], hi_s5 [4][2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 4; a++) begin
				for (int r = 0; r < 2; r++) begin
					logic signed [QW-1:0] l0, l1, h0, h1;
					l0 = (p_s4[a][r][1] < p_s4[a][r][0]) ? p_s4[a][r][1] : p_s4[a][r][0];
					l1 = (p_s4[a][r][3] < p_s4[a][r][2]) ? p_s4[a][r][3] : p_s4[a][r][2];
					h0 = (p_s4[a][r][1] > p_s4[a][r][0]) ? p_s4[a][r][1] : p_s4[a][r][0];
					h1 = (p_s4[a][r][3] > p_s4[a][r][2]) ? p_s4[a][r][3] : p_s4[a][r][2];
					lo_s5[a][r] <= (l1 < l0) ? l1 : l0;
					hi_s5[a][r] <= (h1 > h0) ? h1 : h0;
				end
			end
		end
	end

	// stage 6: separation test
	logic signed [KW-1:0] tol_k;
	logic [3:0]           sep;
	assign tol_k = KW'({tol, {TOL_SHIFT{1'b0}}});

	always_comb begin
		for (int a = 0; a < 4; a++) begin
			sep[a] = (KW'(hi_s5[a][0]) + tol_k < KW'(lo_s5[a][1]))
			      || (KW'(lo_s5[a][0]) > KW'(hi_s5[a][1]) + tol_k);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit <= ~|sep;
		end
	end

endmodule

// ----- rtl/oriented_rectangle_overlap.sv -----
// ---------------------------------------------------------------------------
// oriented_rectangle_overlap
// Separating axis overlap test of two rotated rectangles, fully pipelined.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle; the 16-step CORDIC and the projection
// multipliers are fully pipelined, and the pipe freezes only while a
// finished result is not taken.
// Reset: arst_n clears the valid bits and the tolerance register (to 0).
module oriented_rectangle_overlap import orov_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [TOL_W-1:0]             cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic [COORD_BITS-2:0]        first_width,
	input  logic [COORD_BITS-2:0]        first_height,
	input  logic [ANGLE_BITS-1:0]        first_angle,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic [COORD_BITS-2:0]        second_width,
	input  logic [COORD_BITS-2:0]        second_height,
	input  logic [ANGLE_BITS-1:0]        second_angle,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         overlap
);

`include "oriented_rectangle_overlap_macros.svh"

	localparam int LAT = CORDIC_LAT + GEOM_LAT;
	localparam int SW  = 4 * COORD_BITS - 2;

	logic           en;
	logic [TOL_W-1:0] tol_q;
	logic [LAT-1:0] vld_q;

	assign out_valid = vld_q[LAT-1];
	assign en        = ~out_valid | out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// shape fields ride alongside the CORDIC
	logic [SW-1:0] shape_a_s [CORDIC_LAT];
	logic [SW-1:0] shape_b_s [CORDIC_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			shape_a_s[0] <= {first_x, first_y, first_width, first_height};
			shape_b_s[0] <= {second_x, second_y, second_width, second_height};
			for (int i = 1; i < CORDIC_LAT; i++) begin
				shape_a_s[i] <= shape_a_s[i-1];
				shape_b_s[i] <= shape_b_s[i-1];
			end
		end
	end

	logic signed [TRIG_W-1:0] cos_a, sin_a, cos_b, sin_b;

	orov_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_a (
		.clk     (clk),
		.en      (en),
		.angle   (first_angle),
		.cos_val (cos_a),
		.sin_val (sin_a)
	);

	orov_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_b (
		.clk     (clk),
		.en      (en),
		.angle   (second_angle),
		.cos_val (cos_b),
		.sin_val (sin_b)
	);

	orov_geom #(.COORD_BITS(COORD_BITS)) u_geom (
		.clk     (clk),
		.en      (en),
		.cos_a   (cos_a),
		.sin_a   (sin_a),
		.cos_b   (cos_b),
		.sin_b   (sin_b),
		.shape_a (shape_a_s[CORDIC_LAT-1]),
		.shape_b (shape_b_s[CORDIC_LAT-1]),
		.tol     (tol_q),
		.hit     (overlap)
	);

	`OROV_ASSERT_NEXT(a_accept_enters, clk, arst_n, in_valid && in_ready, vld_q[0])
	`OROV_ASSERT_NOW(a_stall_only_output, clk, arst_n, !in_ready, out_valid && !out_ready)
	`OROV_ASSERT_NEXT(a_freeze_on_stall, clk, arst_n, out_valid && !out_ready, $stable(vld_q))
	`OROV_ASSERT_NEXT(a_idle_no_entry, clk, arst_n, !in_valid && in_ready, !vld_q[0])

endmodule

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Checks the oriented rectangle overlap pipeline. Rectangle pairs go in on a
// valid/ready channel, and a local integer model of the separating axis test
// (CORDIC trig, exact corner projections, tolerance) predicts each overlap
// bit. Both sides idle at random.
// ---------------------------------------------------------------------------
module tb import orov_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 830;
	localparam int WDOG_LIMIT = 20000;
	localparam int DRAIN_CYC  = CORDIC_LAT + GEOM_LAT + 8;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
		logic [15:0]        ang;
	} rect_in_t;

	typedef struct {
		rect_in_t a;
		rect_in_t b;
		int       known;  // -1 when only the predictor decides
	} pair_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [TOL_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	rect_in_t ra = '0, rb = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic overlap;

	always #6 clk = ~clk;

	oriented_rectangle_overlap dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.first_x(ra.x), .first_y(ra.y), .first_width(ra.w),
		.first_height(ra.h), .first_angle(ra.ang),
		.second_x(rb.x), .second_y(rb.y), .second_width(rb.w),
		.second_height(rb.h), .second_angle(rb.ang),
		.out_valid(out_valid), .out_ready(out_ready), .overlap(overlap)
	);

	logic [15:0] tolerance = '0;
	bit          overlap_q[$];
	int          errors = 0;
	int          n_sent = 0, n_hit = 0, n_miss = 0;
	int          idle_cyc = 0;
	bit          timed_out = 0;

	function automatic longint fshift(longint v, int s);
		return v >>> s;  // arithmetic shift is floor shift
	endfunction

	function automatic longint clamp_q14(longint v);
		if (v > 16384) return 16384;
		if (v < -16384) return -16384;
		return v;
	endfunction

	function automatic void trig(input logic [15:0] ang, output longint co,
			output longint si);
		logic [31:0] phase;
		quad_t       quad;
		longint      z, cx, cy, dx, dy, c, s;
		phase = {ang, 16'h0};
		quad = quad_t'(phase[31:30]);
		z = longint'(phase[29:0]);
		cx = 652032875;
		cy = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = fshift(cy, i);
			dy = fshift(cx, i);
			if (z >= 0) begin
				cx -= dx; cy += dy; z -= longint'(ATAN_PHASE[i]);
			end else begin
				cx += dx; cy -= dy; z += longint'(ATAN_PHASE[i]);
			end
		end
		c = clamp_q14(fshift(cx + 32768, 16));
		s = clamp_q14(fshift(cy + 32768, 16));
		case (quad)
			QUAD_0: begin co = c; si = s; end
			QUAD_1: begin co = -s; si = c; end
			QUAD_2: begin co = -c; si = -s; end
			default: begin co = s; si = -c; end
		endcase
	endfunction

	function automatic void corners(input rect_in_t r, output longint px[4],
			output longint py[4], output longint c, output longint s);
		longint bx, by, w, h;
		trig(r.ang, c, s);
		bx = longint'(r.x) * 16384;
		by = longint'(r.y) * 16384;
		w = longint'(r.w);
		h = longint'(r.h);
		px[0] = bx;                 py[0] = by;
		px[1] = bx + c*w;           py[1] = by + s*w;
		px[2] = bx + c*w - s*h;     py[2] = by + s*w + c*h;
		px[3] = bx - s*h;           py[3] = by + c*h;
	endfunction

	function automatic bit rects_overlap(rect_in_t a, rect_in_t b, logic [15:0] tol_r);
		longint apx[4], apy[4], bpx[4], bpy[4], ac, as_, bc, bs;
		longint ax[4], ay[4], tol, lo1, hi1, lo2, hi2, p;
		corners(a, apx, apy, ac, as_);
		corners(b, bpx, bpy, bc, bs);
		ax[0] = as_; ay[0] = -ac;
		ax[1] = ac;  ay[1] = as_;
		ax[2] = bs;  ay[2] = -bc;
		ax[3] = bc;  ay[3] = bs;
		tol = longint'(tol_r) << TOL_SHIFT;
		for (int k = 0; k < 4; k++) begin
			lo1 = apx[0]*ax[k] + apy[0]*ay[k]; hi1 = lo1;
			lo2 = bpx[0]*ax[k] + bpy[0]*ay[k]; hi2 = lo2;
			for (int j = 1; j < 4; j++) begin
				p = apx[j]*ax[k] + apy[j]*ay[k];
				if (p < lo1) lo1 = p;
				if (p > hi1) hi1 = p;
				p = bpx[j]*ax[k] + bpy[j]*ay[k];
				if (p < lo2) lo2 = p;
				if (p > hi2) hi2 = p;
			end
			if (hi1 + tol < lo2 || lo1 > hi2 + tol) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
		return $urandom_range(0, 3);
	endfunction

	function automatic rect_in_t rand_rect(bit near);
		rect_in_t r;
		r.ang = 16'($urandom);
		if (near) begin
			r.x = 16'($urandom_range(0, 1600) - 800);
			r.y = 16'($urandom_range(0, 1600) - 800);
			r.w = 15'($urandom_range(0, 800));
			r.h = 15'($urandom_range(0, 800));
		end else begin
			r.x = 16'($urandom);
			r.y = 16'($urandom);
			r.w = 15'($urandom);
			r.h = 15'($urandom);
		end
		return r;
	endfunction

	// valid stays up between items unless a gap is taken
	task automatic send_pair(rect_in_t a, rect_in_t b, int known);
		bit ok;
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		ok = rects_overlap(a, b, tolerance);
		if (known >= 0 && ok != bit'(known)) begin
			$error("directed row %0d: predictor overlap exp %0d got %0d",
				n_sent, known, ok);
			errors++;
		end
		overlap_q.insert(overlap_q.size(), ok);
		ra <= a;
		rb <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	// Waits for the pipe to empty and the tail to drain, then writes.
	task automatic write_tol(logic [15:0] v);
		in_valid <= 1'b0;
		wait (overlap_q.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tolerance = v;
	endtask

	// result side
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (overlap_q.size() == 0) begin
				$error("overlap result with nothing expected: got %0d", overlap);
				errors++;
			end else begin
				automatic bit exp_ov = overlap_q.pop_front();
				if (overlap !== exp_ov) begin
					$error("overlap: expected %0d actual %0d", exp_ov, overlap);
					errors++;
				end
				if (exp_ov) n_hit++; else n_miss++;
			end
		end
	end

	initial begin : sink_stall
		int g;
		forever begin
			@(posedge clk);
			g = gap_len();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
		else idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= WDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("tb: FAIL");
			$finish;
		end
	end

	pair_row_t rows[$];

	initial begin
		rect_in_t u, v;
		logic [15:0] tols[4];
		rows = '{
			'{'{16'sd0, 16'sd0, 15'd160, 15'd160, 16'h0000},
			  '{16'sd80, 16'sd80, 15'd160, 15'd160, 16'h0000}, 1},
			'{'{16'sd0, 16'sd0, 15'd16, 15'd16, 16'h0000},
			  '{16'sd1000, 16'sd0, 15'd16, 15'd16, 16'h0000}, 0},
			// touching edges count as overlap
			'{'{16'sd0, 16'sd0, 15'd16, 15'd16, 16'h0000},
			  '{16'sd16, 16'sd0, 15'd16, 15'd16, 16'h0000}, -1},
			'{'{-16'sd32768, -16'sd32768, 15'd32767, 15'd32767, 16'h0000},
			  '{16'sd32767, 16'sd32767, 15'd32767, 15'd32767, 16'hFFFF}, -1},
			'{'{16'sd32767, -16'sd32768, 15'd1, 15'd1, 16'h4000},
			  '{-16'sd32768, 16'sd32767, 15'd1, 15'd1, 16'h8000}, -1},
			// degenerate: segment and point
			'{'{16'sd0, 16'sd0, 15'd0, 15'd100, 16'h2000},
			  '{16'sd0, 16'sd50, 15'd0, 15'd0, 16'hC000}, -1},
			'{'{16'sd0, 16'sd0, 15'd0, 15'd0, 16'h0000},
			  '{16'sd0, 16'sd0, 15'd0, 15'd0, 16'h0000}, -1},
			'{'{16'sd100, 16'sd100, 15'd200, 15'd50, 16'h1234},
			  '{16'sd150, 16'sd120, 15'd60, 15'd300, 16'hABCD}, -1},
			'{'{16'sd0, 16'sd0, 15'd100, 15'd100, 16'h6000},
			  '{16'sd150, 16'sd0, 15'd100, 15'd100, 16'hE000}, -1},
			'{'{16'sd0, 16'sd0, 15'd32767, 15'd1, 16'h8000},
			  '{-16'sd100, -16'sd100, 15'd1, 15'd32767, 16'h4000}, -1}
		};
		tols = '{16'd0, 16'd65535, 16'd16, 16'($urandom)};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_pair(rows[i].a, rows[i].b, rows[i].known);
		write_tol(16'd65535);
		foreach (rows[i]) if (i < 5) send_pair(rows[i].a, rows[i].b, -1);

		for (int ph = 0; ph < 4; ph++) begin
			write_tol(tols[ph]);
			for (int n = 0; n < N_RANDOM / 4; n++) begin
				bit near;
				near = ($urandom_range(0, 9) != 0);
				u = rand_rect(near);
				v = rand_rect(near);
				send_pair(u, v, -1);
			end
		end

		in_valid <= 1'b0;
		wait (overlap_q.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		$display("tb: %0d pairs sent, %0d overlapping, %0d separated", n_sent,
			n_hit, n_miss);
		$display("tb: tolerances 0, 16, 65535 and random; errors %0d", errors);
		if (errors == 0 && overlap_q.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule
